@@ design/normalized_multi_pattern_matcher_defines.svh @@
// Assertion macros shared by the matcher RTL.
`ifndef NORMALIZED_MULTI_PATTERN_MATCHER_DEFINES_SVH
`define NORMALIZED_MULTI_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NMPM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NMPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/nmpm_pkg.sv @@
// Shared constants, types and the byte fold function of the pattern matcher.
package nmpm_pkg;

  localparam int MAX_LEN      = 4096;
  localparam int WINDOW_CHARS = 8;
  localparam int NUM_PATTERNS = 3;
  localparam int PAT_CHARS    = 8;
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 4;
  localparam int CODE_W       = 8;
  localparam int PAT_IDX_W    = $clog2(PAT_CHARS);
  localparam int CNT_W        = $clog2(MAX_LEN + 2);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ZERO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTHS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CODES   = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_PATTERN_ZERO = 64'd6777200;
  localparam logic [CFG_DATA_W-1:0] RST_PATTERN_ONE  = 64'd435644102515;
  localparam logic [CFG_DATA_W-1:0] RST_PATTERN_TWO  = 64'd1802661744;
  localparam logic [NUM_PATTERNS*LEN_W-1:0]  RST_LENGTHS = 12'd1107;
  localparam logic [NUM_PATTERNS*CODE_W-1:0] RST_CODES   = 24'd65793;

  typedef logic [BYTE_W-1:0] byte_t;

  // Shift control handed to every cell of the window.
  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  // Item sitting in the window stage, waiting for its pattern check.
  typedef struct packed {
    logic valid;
    logic last;
    logic overflow;
  } stage_t;

  function automatic byte_t fold_byte(input byte_t b);
    byte_t low;
    byte_t res;
    low = b;
    if (b >= "A" && b <= "Z") begin
      low = b + 8'd32;
    end
    case (low)
      "0":     res = "o";
      "1":     res = "i";
      "3":     res = "e";
      "4":     res = "a";
      "5":     res = "s";
      "7":     res = "t";
      "@":     res = "a";
      "$":     res = "s";
      "!":     res = "i";
      "+":     res = "t";
      default: res = low;
    endcase
    return res;
  endfunction

endpackage

@@ design/nmpm_cell.sv @@
// One window cell: holds a folded byte and compares it against each pattern.
module nmpm_cell (
  input  logic                                            clk,
  input  logic                                            rst,
  input  nmpm_pkg::cell_ctl_t                             ctl,
  input  nmpm_pkg::byte_t                                 byte_in,
  input  logic                                            valid_in,
  input  logic [nmpm_pkg::NUM_PATTERNS-1:0][nmpm_pkg::BYTE_W-1:0] want,
  input  logic [nmpm_pkg::NUM_PATTERNS-1:0]               care,
  output nmpm_pkg::byte_t                                 byte_q,
  output logic                                            valid_q,
  output logic [nmpm_pkg::NUM_PATTERNS-1:0]               hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.shift) begin
      // A new string drops whatever the previous one left behind.
      valid_q <= valid_in & ~ctl.restart;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_q <= byte_in;
    end
  end

  always_comb begin
    for (int p = 0; p < nmpm_pkg::NUM_PATTERNS; p++) begin
      hit[p] = ~care[p] | (valid_q & (byte_q == want[p]));
    end
  end

endmodule

@@ design/nmpm_collect.sv @@
// Collects pattern hits per string and holds the result item for the output.
module nmpm_collect (
  input  logic                                           clk,
  input  logic                                           rst,
  input  nmpm_pkg::stage_t                               stage,
  input  logic [nmpm_pkg::NUM_PATTERNS-1:0]              match,
  input  logic [nmpm_pkg::NUM_PATTERNS*nmpm_pkg::CODE_W-1:0] codes,
  input  logic                                           out_ready,
  output logic                                           advance,
  output logic                                           out_valid,
  output logic [nmpm_pkg::CODE_W-1:0]                    out_code,
  output logic                                           out_exceeded
);

  logic [nmpm_pkg::CODE_W-1:0] found;
  logic [nmpm_pkg::CODE_W-1:0] found_next;

  // Hold the window stage only when a final item finds the output still full.
  assign advance = ~(stage.valid & stage.last & out_valid & ~out_ready);

  always_comb begin
    found_next = found;
    for (int p = 0; p < nmpm_pkg::NUM_PATTERNS; p++) begin
      if (match[p]) begin
        found_next = found_next | codes[p*nmpm_pkg::CODE_W +: nmpm_pkg::CODE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid & ~out_ready) | (stage.valid & advance & stage.last);
      if (stage.valid && advance) begin
        if (stage.last) begin
          found <= '0;
        end else begin
          found <= found_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage.valid && advance && stage.last) begin
      out_code     <= stage.overflow ? '0 : found_next;
      out_exceeded <= stage.overflow;
    end
  end

endmodule

@@ design/normalized_multi_pattern_matcher.sv @@
// Normalized multi-pattern matcher: takes one string byte per cycle, folds
// case and look-alike characters, and reports at the end of each string the
// OR of the codes of the three programmed patterns that appeared in it.
// Throughput is one byte per clock with no gaps between strings: the folded
// byte shifts into a chain of eight cells, each comparing its byte against
// the patterns, and the chain advances with each accepted byte. A result
// item reaches the output register through the window stage register once its
// final byte is accepted; input is held back only while a finished result is
// still waiting to be taken and the next final byte needs the output register.
// Strings longer than 4096 bytes report code 0 with the length flag set.
`include "normalized_multi_pattern_matcher_defines.svh"

module normalized_multi_pattern_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] match_code
  output logic [0:0]  m_axis_tuser,   // [0] length_exceeded
  input  logic        cfg_we,
  input  logic [nmpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nmpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int NP = nmpm_pkg::NUM_PATTERNS;
  localparam int WC = nmpm_pkg::WINDOW_CHARS;
  localparam int LW = nmpm_pkg::LEN_W;
  localparam int CW = nmpm_pkg::CNT_W;

  // Configuration registers.
  logic [NP-1:0][nmpm_pkg::CFG_DATA_W-1:0] patterns;
  logic [NP*LW-1:0]                        lengths;
  logic [NP*nmpm_pkg::CODE_W-1:0]          codes;

  always_ff @(posedge clk) begin
    if (rst) begin
      patterns[0] <= nmpm_pkg::RST_PATTERN_ZERO;
      patterns[1] <= nmpm_pkg::RST_PATTERN_ONE;
      patterns[2] <= nmpm_pkg::RST_PATTERN_TWO;
      lengths     <= nmpm_pkg::RST_LENGTHS;
      codes       <= nmpm_pkg::RST_CODES;
    end else if (cfg_we) begin
      case (cfg_index)
        nmpm_pkg::REG_PATTERN_ZERO:    patterns[0] <= cfg_wdata;
        nmpm_pkg::REG_PATTERN_ONE:     patterns[1] <= cfg_wdata;
        nmpm_pkg::REG_PATTERN_TWO:     patterns[2] <= cfg_wdata;
        nmpm_pkg::REG_PATTERN_LENGTHS: lengths <= cfg_wdata[NP*LW-1:0];
        nmpm_pkg::REG_PATTERN_CODES:   codes <= cfg_wdata[NP*nmpm_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input side and string bookkeeping.
  logic             in_accept;
  logic             advance;
  logic             fresh;
  logic [CW-1:0]    byte_count;
  logic [CW-1:0]    byte_count_next;
  logic             stage_valid;
  logic             stage_last;
  nmpm_pkg::stage_t stage;
  nmpm_pkg::byte_t  folded;

  assign s_axis_tready = advance;
  assign in_accept     = s_axis_tvalid & advance;
  assign folded        = nmpm_pkg::fold_byte(s_axis_tdata);

  always_comb begin
    if (fresh) begin
      byte_count_next = CW'(1);
    end else if (byte_count <= CW'(nmpm_pkg::MAX_LEN)) begin
      byte_count_next = byte_count + CW'(1);
    end else begin
      byte_count_next = byte_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh       <= 1'b1;
      byte_count  <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        fresh       <= s_axis_tlast;
        byte_count  <= byte_count_next;
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_last <= s_axis_tlast;
    end
  end

  assign stage = {stage_valid, stage_last, byte_count > CW'(nmpm_pkg::MAX_LEN)};

  // Window cell chain, newest byte in cell 0.
  nmpm_pkg::cell_ctl_t ctl_head;
  nmpm_pkg::cell_ctl_t ctl_body;
  nmpm_pkg::byte_t     cell_byte  [WC];
  logic                cell_valid [WC];
  logic [NP-1:0]       cell_hit   [WC];
  logic [NP-1:0][nmpm_pkg::BYTE_W-1:0] cell_want [WC];
  logic [NP-1:0]       cell_care  [WC];

  assign ctl_head = {in_accept, 1'b0};
  assign ctl_body = {in_accept, fresh};

  // Cell k checks pattern character (length - 1 - k) when k is below the length.
  always_comb begin
    logic [LW-1:0] len;
    logic [LW-1:0] idx;
    for (int k = 0; k < WC; k++) begin
      for (int p = 0; p < NP; p++) begin
        len = lengths[p*LW +: LW];
        idx = len - LW'(k) - LW'(1);
        cell_care[k][p] = LW'(k) < len;
        cell_want[k][p] =
          patterns[p][idx[nmpm_pkg::PAT_IDX_W-1:0]*nmpm_pkg::BYTE_W +: nmpm_pkg::BYTE_W];
      end
    end
  end

  for (genvar k = 0; k < WC; k++) begin : g_cell
    if (k == 0) begin : g_head
      nmpm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl_head),
        .byte_in  (folded),
        .valid_in (1'b1),
        .want     (cell_want[k]),
        .care     (cell_care[k]),
        .byte_q   (cell_byte[k]),
        .valid_q  (cell_valid[k]),
        .hit      (cell_hit[k])
      );
    end else begin : g_body
      nmpm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (ctl_body),
        .byte_in  (cell_byte[k-1]),
        .valid_in (cell_valid[k-1]),
        .want     (cell_want[k]),
        .care     (cell_care[k]),
        .byte_q   (cell_byte[k]),
        .valid_q  (cell_valid[k]),
        .hit      (cell_hit[k])
      );
    end
  end

  // A pattern matches when it is enabled and every cell under it agrees.
  logic [NP-1:0] match;

  always_comb begin
    logic [LW-1:0] len;
    for (int p = 0; p < NP; p++) begin
      len      = lengths[p*LW +: LW];
      match[p] = (len != '0) && (len <= LW'(WC));
      for (int k = 0; k < WC; k++) begin
        match[p] = match[p] & cell_hit[k][p];
      end
    end
  end

  nmpm_collect u_collect (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .match        (match),
    .codes        (codes),
    .out_ready    (m_axis_tready),
    .advance      (advance),
    .out_valid    (m_axis_tvalid),
    .out_code     (m_axis_tdata),
    .out_exceeded (m_axis_tuser[0])
  );

  `NMPM_ASSERT_NEXT(a_restart_count, in_accept && fresh, byte_count == CW'(1), "string count did not restart")
  `NMPM_ASSERT_NEXT(a_head_valid, in_accept, cell_valid[0] && stage.valid, "accepted item missing from window")
  `NMPM_ASSERT_SAME(a_overflow_code, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "overlong string reported a code")
  `NMPM_ASSERT_SAME(a_stall_cause, !s_axis_tready, stage.valid && stage.last && m_axis_tvalid, "input held without a waiting final item")

endmodule

@@ tb/normalized_multi_pattern_matcher_tb.sv @@
// Self-checking testbench for the normalized multi-pattern matcher.
module normalized_multi_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [7:0] code;
    logic       overlong;
  } verdict_t;

  // Tracks the matcher's per-string state and the verdicts still owed by the block.
  class match_scoreboard;
    logic [nmpm_pkg::CFG_DATA_W-1:0] pat [nmpm_pkg::NUM_PATTERNS];
    logic [nmpm_pkg::NUM_PATTERNS*nmpm_pkg::LEN_W-1:0] lens;
    logic [nmpm_pkg::NUM_PATTERNS*nmpm_pkg::CODE_W-1:0] codes;
    logic [7:0] win [nmpm_pkg::WINDOW_CHARS];
    int fill;
    int count;
    logic [7:0] found;
    verdict_t verdict_q[$];
    int errors;

    function new();
      pat[0] = nmpm_pkg::RST_PATTERN_ZERO;
      pat[1] = nmpm_pkg::RST_PATTERN_ONE;
      pat[2] = nmpm_pkg::RST_PATTERN_TWO;
      lens = nmpm_pkg::RST_LENGTHS;
      codes = nmpm_pkg::RST_CODES;
      errors = 0;
      clear_string();
    endfunction

    function void clear_string();
      foreach (win[i]) win[i] = 8'h00;
      fill = 0;
      count = 0;
      found = 8'h00;
    endfunction

    function void write_reg(logic [nmpm_pkg::CFG_IDX_W-1:0] idx,
                            logic [nmpm_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        nmpm_pkg::REG_PATTERN_ZERO:    pat[0] = val;
        nmpm_pkg::REG_PATTERN_ONE:     pat[1] = val;
        nmpm_pkg::REG_PATTERN_TWO:     pat[2] = val;
        nmpm_pkg::REG_PATTERN_LENGTHS:
          lens = val[nmpm_pkg::NUM_PATTERNS*nmpm_pkg::LEN_W-1:0];
        nmpm_pkg::REG_PATTERN_CODES:
          codes = val[nmpm_pkg::NUM_PATTERNS*nmpm_pkg::CODE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] fold_char(logic [7:0] b);
      logic [7:0] v;
      v = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
      case (v)
        "0", "+", "7": v = (v == "0") ? "o" : "t";
        "1", "!":      v = "i";
        "3":           v = "e";
        "4", "@":      v = "a";
        "5", "$":      v = "s";
        default: ;
      endcase
      return v;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int len;
      bit hit;
      verdict_t v;
      for (int i = nmpm_pkg::WINDOW_CHARS - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = fold_char(b);
      if (fill < nmpm_pkg::WINDOW_CHARS) fill++;
      if (count <= nmpm_pkg::MAX_LEN) count++;
      for (int p = 0; p < nmpm_pkg::NUM_PATTERNS; p++) begin
        len = lens[nmpm_pkg::LEN_W*p +: nmpm_pkg::LEN_W];
        if (len != 0 && len <= nmpm_pkg::WINDOW_CHARS && fill >= len) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++)
            if (win[len-1-j] != pat[p][8*j +: 8]) hit = 1'b0;
          if (hit) found |= codes[nmpm_pkg::CODE_W*p +: nmpm_pkg::CODE_W];
        end
      end
      if (last) begin
        v.overlong = (count > nmpm_pkg::MAX_LEN);
        v.code = v.overlong ? 8'h00 : found;
        verdict_q.push_back(v);
        clear_string();
      end
    endfunction

    function void check_result(logic [7:0] code, logic overlong);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result: match_code %02h length_exceeded %0b",
                 $time, code, overlong);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (code !== v.code) begin
        $display("%0t: match_code mismatch: expected %02h actual %02h",
                 $time, v.code, code);
        errors++;
      end
      if (overlong !== v.overlong) begin
        $display("%0t: length_exceeded mismatch: expected %0b actual %0b",
                 $time, v.overlong, overlong);
        errors++;
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] text_byte
  logic s_axis_tlast = 1'b0;          // last_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] match_code
  logic [0:0] m_axis_tuser;           // [0] length_exceeded
  logic cfg_we = 1'b0;
  logic [nmpm_pkg::CFG_IDX_W-1:0] cfg_index = nmpm_pkg::REG_PATTERN_ZERO;
  logic [nmpm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  match_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  int random_sent;

  normalized_multi_pattern_matcher u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Pick a raw byte that folds to c: the byte itself, its uppercase or a look-alike.
  function automatic logic [7:0] raw_for(logic [7:0] c);
    logic [7:0] alt [$];
    alt.push_back(c);
    if (c >= "a" && c <= "z") alt.push_back(c - 8'd32);
    case (c)
      "o": alt.push_back("0");
      "i": begin alt.push_back("1"); alt.push_back("!"); end
      "e": alt.push_back("3");
      "a": begin alt.push_back("4"); alt.push_back("@"); end
      "s": begin alt.push_back("5"); alt.push_back("$"); end
      "t": begin alt.push_back("7"); alt.push_back("+"); end
      default: ;
    endcase
    return alt[$urandom_range(alt.size() - 1)];
  endfunction

  function automatic logic [7:0] pick_char();
    int p;
    int k;
    p = $urandom_range(nmpm_pkg::NUM_PATTERNS - 1);
    k = $urandom_range(nmpm_pkg::PAT_CHARS - 1);
    return sb.pat[p][8*k +: 8];
  endfunction

  function automatic logic [nmpm_pkg::CFG_DATA_W-1:0] rand_pattern();
    string alphabet;
    logic [nmpm_pkg::CFG_DATA_W-1:0] v;
    alphabet = "aeiostgknprw";
    for (int j = 0; j < nmpm_pkg::PAT_CHARS; j++)
      v[8*j +: 8] = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                             : alphabet[$urandom_range(alphabet.len() - 1)];
    return v;
  endfunction

  function automatic logic [nmpm_pkg::NUM_PATTERNS*nmpm_pkg::LEN_W-1:0] rand_lengths(
      int lo, int hi);
    logic [nmpm_pkg::NUM_PATTERNS*nmpm_pkg::LEN_W-1:0] v;
    for (int p = 0; p < nmpm_pkg::NUM_PATTERNS; p++)
      v[nmpm_pkg::LEN_W*p +: nmpm_pkg::LEN_W] = nmpm_pkg::LEN_W'($urandom_range(lo, hi));
    return v;
  endfunction

  task automatic send_item(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, last);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
  endtask

  // Mostly pattern fragments in random spelling, some cut short, some noise.
  task automatic send_string();
    logic [7:0] q [$];
    int n;
    int r;
    int p;
    int l;
    n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
    while (q.size() < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        p = $urandom_range(nmpm_pkg::NUM_PATTERNS - 1);
        l = sb.lens[nmpm_pkg::LEN_W*p +: nmpm_pkg::LEN_W];
        if (l == 0 || l > nmpm_pkg::WINDOW_CHARS) l = $urandom_range(1, nmpm_pkg::PAT_CHARS);
        if ($urandom_range(4) == 0) l = $urandom_range(1, l);
        for (int j = 0; j < l; j++) q.push_back(raw_for(sb.pat[p][8*j +: 8]));
      end else if (r < 70) begin
        q.push_back(raw_for(pick_char()));
      end else begin
        q.push_back(8'($urandom_range(255)));
      end
    end
    foreach (q[i]) send_item(q[i], i == q.size() - 1);
    random_sent += q.size();
  endtask

  // Hold the sender until every owed verdict has come back.
  task automatic hold_until_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic drain();
    hold_until_done();
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [nmpm_pkg::CFG_IDX_W-1:0] idx,
                         logic [nmpm_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(int ph);
    logic [nmpm_pkg::CFG_DATA_W-1:0] rnd;
    case (ph)
      0: begin
        set_reg(nmpm_pkg::REG_PATTERN_ZERO, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_ONE, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_TWO, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS,
                64'(rand_lengths(1, nmpm_pkg::WINDOW_CHARS)));
        set_reg(nmpm_pkg::REG_PATTERN_CODES, 64'($urandom_range(24'hFFFFFF)));
      end
      1: begin
        set_reg(nmpm_pkg::REG_PATTERN_ZERO, '1);
        set_reg(nmpm_pkg::REG_PATTERN_ONE, '0);
        set_reg(nmpm_pkg::REG_PATTERN_TWO, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS, 64'h888);
        set_reg(nmpm_pkg::REG_PATTERN_CODES, 64'hFFFFFF);
      end
      2: begin
        // lengths 0, 9 and 15 all disable their pattern
        set_reg(nmpm_pkg::REG_PATTERN_ZERO, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_ONE, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS, 64'hF90);
        set_reg(nmpm_pkg::REG_PATTERN_CODES, 64'($urandom_range(24'hFFFFFF)));
      end
      3: begin
        set_reg(nmpm_pkg::REG_PATTERN_TWO, rand_pattern());
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS, 64'(rand_lengths(1, 3)));
        set_reg(nmpm_pkg::REG_PATTERN_CODES, '0);
      end
      4: begin
        rnd = {$urandom, $urandom};
        set_reg(nmpm_pkg::REG_PATTERN_ZERO, rnd);
        rnd = {$urandom, $urandom};
        set_reg(nmpm_pkg::REG_PATTERN_ONE, rnd);
        rnd = {$urandom, $urandom};
        set_reg(nmpm_pkg::REG_PATTERN_TWO, rnd);
        rnd = {$urandom, $urandom};
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS, rnd);
        rnd = {$urandom, $urandom};
        set_reg(nmpm_pkg::REG_PATTERN_CODES, rnd);
      end
      default: begin
        set_reg(nmpm_pkg::REG_PATTERN_ZERO, nmpm_pkg::RST_PATTERN_ZERO);
        set_reg(nmpm_pkg::REG_PATTERN_ONE, nmpm_pkg::RST_PATTERN_ONE);
        set_reg(nmpm_pkg::REG_PATTERN_TWO, nmpm_pkg::RST_PATTERN_TWO);
        set_reg(nmpm_pkg::REG_PATTERN_LENGTHS, 64'(nmpm_pkg::RST_LENGTHS));
        set_reg(nmpm_pkg::REG_PATTERN_CODES, 64'(nmpm_pkg::RST_CODES));
      end
    endcase
    // indexes past the register list must be ignored
    rnd = {$urandom, $urandom};
    set_reg(nmpm_pkg::REG_PATTERN_CODES + nmpm_pkg::CFG_IDX_W'(1 + $urandom_range(2)), rnd);
    // drop the write enable after the last register
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 63; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 63; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  initial begin
    bit paused;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset patterns in plain, mixed-case and look-alike spelling
    send_text("P1G");
    send_text("5W!N3");
    send_text("p0rk");
    send_text("x+@$7");
    // zero byte, high bytes that must not fold, and a near miss on the first pattern
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b0);
    send_item("P", 1'b0);
    send_item("I", 1'b0);
    send_item(8'hC7, 1'b1);
    send_text("p");

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      apply_config(ph);
      set_idling(ph % 4);
      random_sent = 0;
      paused = 1'b0;
      while (random_sent < ITEMS_PER_PHASE) begin
        send_string();
        if (ph % 4 == 1 && !paused && random_sent >= ITEMS_PER_PHASE / 2) begin
          hold_until_done();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
